// ----- src/pprs_pkg.sv -----
// shared types and constants for the projected point region select block
`default_nettype none
package pprs_pkg;
    localparam int MAX_VERTICES_DEF = 64;
    localparam int INDEX_BITS_DEF   = 24;
    localparam int NUM_REGS         = 8;

    localparam logic [2:0] REG_ROW0   = 3'd0;
    localparam logic [2:0] REG_ROW1   = 3'd1;
    localparam logic [2:0] REG_ROW2   = 3'd2;
    localparam logic [2:0] REG_ROW3   = 3'd3;
    localparam logic [2:0] REG_WINDOW = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;
    localparam logic [2:0] REG_RECT   = 3'd6;
    localparam logic [2:0] REG_VCOUNT = 3'd7;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_POINT = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               first_of_cloud;
        logic [5:0]         vertex_slot;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
    } t_in_item;

    // request / reply between sequencer and divider
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [37:0] quo;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- src/pprs_div.sv -----
// shared restoring divider: quotient with 24 fraction bits, clamped at 2^13
`default_nettype none
module pprs_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pprs_pkg::t_div_req i_req,
    output pprs_pkg::t_div_rsp     o_rsp
);
    // long division over 64 integer bits then 24 fraction bits
    localparam int STEPS = 88;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [64:0] r_rem, n_rem;
    logic [63:0] r_num, n_num;
    logic [63:0] r_den, n_den;
    logic [37:0] r_quo, n_quo;
    logic        r_ovf, n_ovf;
    logic        r_done, n_done;
    logic [64:0] shifted;
    logic        bit_in;

    always_comb begin
        n_cnt = r_cnt; n_busy = r_busy; n_rem = r_rem; n_num = r_num;
        n_den = r_den; n_quo = r_quo; n_ovf = r_ovf; n_done = 1'b0;
        bit_in  = r_num[63];
        shifted = {r_rem[63:0], bit_in};
        if (i_req.start) begin
            n_busy = 1'b1; n_cnt = '0; n_rem = '0; n_num = i_req.num;
            n_den = i_req.den; n_quo = '0; n_ovf = 1'b0;
        end else if (r_busy) begin
            n_num = {r_num[62:0], 1'b0};
            if (shifted >= {1'b0, r_den}) begin
                n_rem = shifted - {1'b0, r_den};
                // quotient bit at weight 2^13 or above in integer part clamps
                if (r_cnt < 7'd51) n_ovf = 1'b1;
                n_quo = {r_quo[36:0], 1'b1};
            end else begin
                n_rem = shifted;
                n_quo = {r_quo[36:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_rem <= n_rem; r_num <= n_num; r_den <= n_den;
        r_quo <= n_quo; r_ovf <= n_ovf;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_ovf ? 38'(64'd8192 << 24) : r_quo;
endmodule
`default_nettype wire

// ----- src/projected_point_region_select_top.sv -----
// top level: projection, perspective divide and region test sequencer
// A point of a live cloud passes, in rectangle mode, through 12 multiply steps for the
// matrix rows, one w check, two passes through the shared 88-step divider for the
// perspective ratio, four scaling steps and one select step before its result is valid.
// In polygon mode each edge adds a vertex read, a vertex wait and a compare step, and a
// second multiply step when the edge straddles the point's row. A point of a halted
// cloud gives its result in the cycle after its transfer. A vertex load is written on
// its transfer. The block is not ready while a point is in work or its result waits
// to be taken; the result is held in an output register until its transfer, and the
// block is ready again the cycle after.
`default_nettype none
module projected_point_region_select_top #(
    parameter int MAX_VERTICES = pprs_pkg::MAX_VERTICES_DEF,
    parameter int INDEX_BITS   = pprs_pkg::INDEX_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire pprs_pkg::t_in_item i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [INDEX_BITS-1:0]   o_point_index,
    output logic                    o_selected,
    output logic                    o_halted,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data
);
    localparam int VB = $clog2(MAX_VERTICES);
    localparam int CB = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIVX, S_WX, S_DIVY, S_WY, S_SCALE, S_SEL,
        S_PREAD, S_PWAIT, S_PMUL1, S_PMUL2, S_OUT
    } t_state;

    // configuration registers
    logic [63:0] r_row0, r_row1, r_row2, r_row3, r_rect;
    logic [31:0] r_win;
    logic        r_mode;
    logic [6:0]  r_vcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row0 <= '0; r_row1 <= '0; r_row2 <= '0; r_row3 <= '0;
            r_win <= '0; r_mode <= 1'b0; r_rect <= '0; r_vcnt <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pprs_pkg::REG_ROW0:   r_row0 <= i_cfg_data;
                pprs_pkg::REG_ROW1:   r_row1 <= i_cfg_data;
                pprs_pkg::REG_ROW2:   r_row2 <= i_cfg_data;
                pprs_pkg::REG_ROW3:   r_row3 <= i_cfg_data;
                pprs_pkg::REG_WINDOW: r_win  <= i_cfg_data[31:0];
                pprs_pkg::REG_MODE:   r_mode <= i_cfg_data[0];
                pprs_pkg::REG_RECT:   r_rect <= i_cfg_data;
                pprs_pkg::REG_VCOUNT: r_vcnt <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // vertex memory
    logic [31:0] r_vmem [MAX_VERTICES];
    logic [31:0] r_vrd;
    logic [VB-1:0] vaddr;

    wire accept = i_valid && o_ready;
    always_ff @(posedge i_clk) begin
        if (accept && i_data.command == pprs_pkg::CMD_LOAD
                && 32'(i_data.vertex_slot) < 32'(MAX_VERTICES))
            r_vmem[VB'(i_data.vertex_slot)] <= {i_data.vertex_y, i_data.vertex_x};
        r_vrd <= r_vmem[vaddr];
    end

    // shared divider
    pprs_pkg::t_div_req div_req;
    pprs_pkg::t_div_rsp div_rsp;
    pprs_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req), .o_rsp(div_rsp));

    t_state r_state;
    logic [3:0]  r_step;
    logic signed [31:0] r_x, r_y, r_z;
    logic signed [49:0] r_acc [3];    // px, py, pw in Q.28
    logic [63:0] r_prod;
    logic [37:0] r_tx, r_ty;
    logic        r_negx, r_negy, r_zx, r_zy;
    logic signed [15:0] r_sx, r_sy;
    logic [INDEX_BITS-1:0] r_cnt;
    logic        r_halt, r_sel;
    logic [CB-1:0] r_edge, r_n;
    logic [31:0] r_vi, r_v0;
    logic        r_odd;
    logic signed [35:0] r_lhs;
    logic [3:0]  r_ecnt;

    // one multiplier shared by matrix, scaling and edge steps
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic [63:0] row_sel;
    logic [1:0]  row_i, col_i;
    assign row_i = r_step[3:2];
    assign col_i = r_step[1:0];
    always_comb begin
        case (row_i)
            2'd0:    row_sel = r_row0;
            2'd1:    row_sel = r_row1;
            default: row_sel = r_row3;
        endcase
    end

    // numerator for the ratio (p + w) and sign
    logic signed [50:0] nx, ny;
    assign nx = 51'(r_acc[0]) + 51'(r_acc[2]);
    assign ny = 51'(r_acc[1]) + 51'(r_acc[2]);
    logic [63:0] wmag;
    assign wmag = r_acc[2][49] ? 64'(-51'(r_acc[2])) : 64'(r_acc[2]);

    // edge vertex fields
    logic signed [15:0] xi, yi, xj, yj;
    assign xi = r_vi[15:0];  assign yi = r_vi[31:16];
    assign xj = r_vrd[15:0]; assign yj = r_vrd[31:16];
    logic straddle;
    assign straddle = (yi < r_sy && yj >= r_sy) || (yj < r_sy && yi >= r_sy);
    logic signed [16:0] dy;
    assign dy = 17'(yj) - 17'(yi);

    // vertex j stays on the read port through the whole edge, and is vertex i
    // of the next edge when that one starts
    logic [CB-1:0] nxt_edge;
    assign nxt_edge = (r_edge + CB'(1) == r_n) ? '0 : r_edge + CB'(1);
    assign vaddr = (r_state == S_SEL) ? VB'(0) : VB'(nxt_edge);

    // saturated screen value from ratio product
    function automatic logic signed [15:0] sat(input logic [63:0] prod, input logic neg,
                                               input logic zero);
        logic [63:0] mag;
        mag = (prod + (64'd1 << 23)) >> 24;
        if (zero) return '0;
        if (neg) return (mag > 64'd32768) ? 16'sh8000 : 16'(-mag);
        return (mag > 64'd32767) ? 16'sh7fff : 16'(mag);
    endfunction

    always_comb begin
        mul_a = '0; mul_b = '0;
        div_req.start = 1'b0;
        div_req.num = '0;
        div_req.den = wmag;
        case (r_state)
            S_MUL: begin
                mul_b = 33'(signed'(row_sel[16*col_i +: 16]));
                case (col_i)
                    2'd0: mul_a = 33'(r_x);
                    2'd1: mul_a = 33'(r_y);
                    2'd2: mul_a = 33'(r_z);
                    default: mul_a = 33'sd65536;
                endcase
            end
            S_SCALE: begin
                // ratio split in a low 32-bit part and a high part
                case (r_step[1:0])
                    2'd0: mul_a = 33'(r_tx[31:0]);
                    2'd1: mul_a = 33'(r_tx[37:32]);
                    2'd2: mul_a = 33'(r_ty[31:0]);
                    default: mul_a = 33'(r_ty[37:32]);
                endcase
                mul_b = 33'({r_step[1] ? r_win[31:16] : r_win[15:0], 3'b000});
            end
            S_PMUL1: begin
                mul_a = 33'(r_sy) - 33'(yi);
                mul_b = 33'(xj) - 33'(xi);
            end
            S_PMUL2: begin
                mul_a = 33'(r_sx) - 33'(xi);
                mul_b = 33'(dy);
            end
            default: ;
        endcase
        if (r_state == S_WX && r_step == 4'd0) begin
            div_req.start = 1'b1;
            div_req.num = nx[50] ? 64'(-nx) : 64'(nx);
        end
        if (r_state == S_WY && r_step == 4'd0) begin
            div_req.start = 1'b1;
            div_req.num = ny[50] ? 64'(-ny) : 64'(ny);
        end
    end

    logic signed [15:0] rminx, rminy, rmaxx, rmaxy;
    assign rminx = r_rect[15:0];  assign rminy = r_rect[31:16];
    assign rmaxx = r_rect[47:32]; assign rmaxy = r_rect[63:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= '0; r_halt <= 1'b0; r_step <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (accept && i_data.command == pprs_pkg::CMD_POINT) begin
                    r_x <= i_data.coord_x; r_y <= i_data.coord_y; r_z <= i_data.coord_z;
                    if (i_data.first_of_cloud) begin
                        r_cnt <= '0; r_halt <= 1'b0;
                    end
                    r_sel <= 1'b0;
                    r_acc[0] <= '0; r_acc[1] <= '0; r_acc[2] <= '0;
                    r_step <= '0;
                    r_state <= (i_data.first_of_cloud || !r_halt) ? S_MUL : S_OUT;
                end
                S_MUL: begin
                    r_acc[(row_i == 2'd0) ? 0 : (row_i == 2'd1) ? 1 : 2] <=
                        r_acc[(row_i == 2'd0) ? 0 : (row_i == 2'd1) ? 1 : 2] + 50'(mul_p);
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd11) begin
                        r_step <= '0;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX: begin
                    if (r_acc[2] == '0) begin
                        r_halt <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_negx <= nx[50] != r_acc[2][49];
                        r_negy <= ny[50] != r_acc[2][49];
                        r_zx <= nx == '0; r_zy <= ny == '0;
                        r_state <= S_WX;
                    end
                end
                S_WX: begin
                    r_step <= 4'd1;
                    if (div_rsp.done) begin
                        r_tx <= div_rsp.quo; r_step <= '0; r_state <= S_DIVY;
                    end
                end
                S_DIVY: r_state <= S_WY;
                S_WY: begin
                    r_step <= 4'd1;
                    if (div_rsp.done) begin
                        r_ty <= div_rsp.quo; r_step <= '0; r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_step <= r_step + 4'd1;
                    case (r_step[1:0])
                        2'd0, 2'd2: r_prod <= 64'(mul_p);
                        2'd1: r_sx <= sat(r_prod + (64'(mul_p) << 32), r_negx, r_zx);
                        default: begin
                            r_sy <= sat(r_prod + (64'(mul_p) << 32), r_negy, r_zy);
                            r_step <= '0;
                            r_state <= S_SEL;
                        end
                    endcase
                end
                S_SEL: begin
                    r_n <= (32'(r_vcnt) > 32'(MAX_VERTICES)) ? CB'(MAX_VERTICES)
                                                              : CB'(r_vcnt);
                    r_edge <= '0; r_odd <= 1'b0; r_ecnt <= '0;
                    if (!r_mode) begin
                        r_sel <= r_sx >= rminx && r_sy >= rminy &&
                                 r_sx <= rmaxx && r_sy <= rmaxy;
                        r_state <= S_OUT;
                    end else if (r_vcnt < 7'd3) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PREAD;
                    end
                end
                S_PREAD: begin
                    r_vi <= r_vrd;
                    r_state <= S_PWAIT;
                end
                S_PWAIT: r_state <= straddle ? S_PMUL1 : S_PMUL2;
                S_PMUL1: begin
                    r_lhs <= 36'(mul_p);
                    r_state <= S_PMUL2;
                    r_ecnt <= 4'd1;
                end
                S_PMUL2: begin
                    if (r_ecnt == 4'd1 &&
                        ((dy > 0) ? (64'(r_lhs) < 64'(mul_p)) : (64'(r_lhs) > 64'(mul_p))))
                        r_odd <= ~r_odd;
                    r_ecnt <= '0;
                    if (nxt_edge == '0) begin
                        r_sel <= r_odd ^ (r_ecnt == 4'd1 &&
                            ((dy > 0) ? (64'(r_lhs) < 64'(mul_p))
                                      : (64'(r_lhs) > 64'(mul_p))));
                        r_state <= S_OUT;
                    end else begin
                        r_edge <= nxt_edge;
                        r_state <= S_PREAD;
                    end
                end
                S_OUT: if (i_ready) begin
                    r_cnt <= r_cnt + INDEX_BITS'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // vertex zero is read in S_SEL; each later vertex i is already on the read
    // port as vertex j of the previous edge, so S_PREAD takes it into r_vi while
    // the port moves on to the next vertex j
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_point_index = r_cnt;
    assign o_selected    = r_sel & ~r_halt;
    assign o_halted      = r_halt;
endmodule
`default_nettype wire

// ----- src/pprs_checker.sv -----
// port-level checker for the projected point region select block
`default_nettype none
module pprs_props #(
    parameter int INDEX_BITS = pprs_pkg::INDEX_BITS_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_ready,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic                  o_selected,
    input wire logic                  o_halted,
    input wire logic [INDEX_BITS-1:0] o_point_index
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_point_index))
        else $error("result dropped");
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_halted |-> !o_selected) else $error("selected while halted");
    a_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid) else $error("result repeated");
endmodule

bind projected_point_region_select_top pprs_props #(.INDEX_BITS(INDEX_BITS)) u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready), .o_valid(o_valid),
    .i_ready(i_ready), .o_selected(o_selected), .o_halted(o_halted),
    .o_point_index(o_point_index)
);
`default_nettype wire
